### rtl/rv32d_pkg.sv
package rv32d_pkg;

    // Field widths of the instruction word and the decoded result.
    localparam int unsigned WordWidth   = 32;
    localparam int unsigned RegIdxWidth = 5;
    localparam int unsigned IdWidth     = 5;
    localparam int unsigned OpcWidth    = 7;
    localparam int unsigned Funct3Width = 3;
    localparam int unsigned Funct7Width = 7;

    // Major opcodes of the supported subset.
    localparam logic [OpcWidth-1:0] OPC_LOAD   = 7'b0000011;
    localparam logic [OpcWidth-1:0] OPC_STORE  = 7'b0100011;
    localparam logic [OpcWidth-1:0] OPC_LUI    = 7'b0110111;
    localparam logic [OpcWidth-1:0] OPC_OP_IMM = 7'b0010011;
    localparam logic [OpcWidth-1:0] OPC_AUIPC  = 7'b0010111;
    localparam logic [OpcWidth-1:0] OPC_JAL    = 7'b1101111;
    localparam logic [OpcWidth-1:0] OPC_JALR   = 7'b1100111;
    localparam logic [OpcWidth-1:0] OPC_BRANCH = 7'b1100011;
    localparam logic [OpcWidth-1:0] OPC_OP     = 7'b0110011;
    localparam logic [OpcWidth-1:0] OPC_TRAP   = 7'b1101011;

    // Minor function codes.
    localparam logic [Funct3Width-1:0] F3_ADD  = 3'b000;
    localparam logic [Funct3Width-1:0] F3_BNE  = 3'b001;
    localparam logic [Funct3Width-1:0] F3_SLT  = 3'b010;
    localparam logic [Funct3Width-1:0] F3_SLTU = 3'b011;
    localparam logic [Funct3Width-1:0] F3_WORD = 3'b010;
    localparam logic [Funct3Width-1:0] F3_BEQ  = 3'b000;
    localparam logic [Funct3Width-1:0] F3_JALR = 3'b000;

    localparam logic [Funct7Width-1:0] F7_BASE = 7'b0000000;
    localparam logic [Funct7Width-1:0] F7_ALT  = 7'b0100000;

    // Instruction identifiers as seen on the result channel.
    typedef enum logic [IdWidth-1:0] {
        ID_LW      = 5'd0,
        ID_SW      = 5'd1,
        ID_LUI     = 5'd2,
        ID_ADDI    = 5'd3,
        ID_AUIPC   = 5'd4,
        ID_JAL     = 5'd5,
        ID_JALR    = 5'd6,
        ID_BEQ     = 5'd7,
        ID_SLTIU   = 5'd8,
        ID_SLTI    = 5'd9,
        ID_BNE     = 5'd10,
        ID_ADD     = 5'd11,
        ID_SUB     = 5'd12,
        ID_SLTU    = 5'd13,
        ID_SLT     = 5'd14,
        ID_TRAP    = 5'd15,
        ID_INVALID = 5'd16
    } instr_id_t;

    // Encoding formats; FMT_NONE covers trap and invalid words.
    typedef enum logic [2:0] {
        FMT_NONE = 3'd0,
        FMT_I    = 3'd1,
        FMT_S    = 3'd2,
        FMT_U    = 3'd3,
        FMT_J    = 3'd4,
        FMT_B    = 3'd5,
        FMT_R    = 3'd6
    } fmt_t;

    // Classification of one word, handed from the classifier to the pipeline.
    typedef struct packed {
        instr_id_t id;
        fmt_t      fmt;
    } class_t;

endpackage

### rtl/rv32d_if.sv
// Channel carrying raw instruction words into the decoder.
interface rv32d_instr_if
    import rv32d_pkg::*;
();
    logic                 valid;
    logic                 ready;
    logic [WordWidth-1:0] instr_word;

    modport source (output valid, output instr_word, input ready);
    modport sink   (input valid, input instr_word, output ready);
endinterface

// Channel carrying decoded results out of the decoder.
interface rv32d_result_if
    import rv32d_pkg::*;
();
    logic                        valid;
    logic                        ready;
    logic [IdWidth-1:0]          instr_id;
    logic [RegIdxWidth-1:0]      rd_index;
    logic [RegIdxWidth-1:0]      rs1_index;
    logic [RegIdxWidth-1:0]      rs2_index;
    logic signed [WordWidth-1:0] immediate;
    logic                        writes_register;

    modport source (
        output valid, output instr_id, output rd_index, output rs1_index,
        output rs2_index, output immediate, output writes_register,
        input ready
    );
    modport sink (
        input valid, input instr_id, input rd_index, input rs1_index,
        input rs2_index, input immediate, input writes_register,
        output ready
    );
endinterface

### rtl/rv32d_classify.sv
// Matches one instruction word against the supported subset and yields the
// instruction id and its encoding format. The first matching pattern wins.
module rv32d_classify
    import rv32d_pkg::*;
(
    input  logic [WordWidth-1:0] word,
    output class_t               cls
);

    logic [OpcWidth-1:0]    opc;
    logic [Funct3Width-1:0] f3;
    logic [Funct7Width-1:0] f7;

    assign opc = word[6:0];
    assign f3  = word[14:12];
    assign f7  = word[31:25];

    // Opcode decode, then the minor function codes inside each opcode.
    always_comb
    begin
        cls.id  = ID_INVALID;
        cls.fmt = FMT_NONE;
        unique case (opc)
            OPC_LOAD:
            begin
                if (f3 == F3_WORD)
                begin
                    cls.id  = ID_LW;
                    cls.fmt = FMT_I;
                end
            end
            OPC_STORE:
            begin
                if (f3 == F3_WORD)
                begin
                    cls.id  = ID_SW;
                    cls.fmt = FMT_S;
                end
            end
            OPC_LUI:
            begin
                cls.id  = ID_LUI;
                cls.fmt = FMT_U;
            end
            OPC_OP_IMM:
            begin
                if (f3 == F3_ADD)
                begin
                    cls.id  = ID_ADDI;
                    cls.fmt = FMT_I;
                end
                else if (f3 == F3_SLTU)
                begin
                    cls.id  = ID_SLTIU;
                    cls.fmt = FMT_I;
                end
                else if (f3 == F3_SLT)
                begin
                    cls.id  = ID_SLTI;
                    cls.fmt = FMT_I;
                end
            end
            OPC_AUIPC:
            begin
                cls.id  = ID_AUIPC;
                cls.fmt = FMT_U;
            end
            OPC_JAL:
            begin
                cls.id  = ID_JAL;
                cls.fmt = FMT_J;
            end
            OPC_JALR:
            begin
                if (f3 == F3_JALR)
                begin
                    cls.id  = ID_JALR;
                    cls.fmt = FMT_I;
                end
            end
            OPC_BRANCH:
            begin
                if (f3 == F3_BEQ)
                begin
                    cls.id  = ID_BEQ;
                    cls.fmt = FMT_B;
                end
                else if (f3 == F3_BNE)
                begin
                    cls.id  = ID_BNE;
                    cls.fmt = FMT_B;
                end
            end
            OPC_OP:
            begin
                if (f7 == F7_BASE && f3 == F3_ADD)
                begin
                    cls.id  = ID_ADD;
                    cls.fmt = FMT_R;
                end
                else if (f7 == F7_ALT && f3 == F3_ADD)
                begin
                    cls.id  = ID_SUB;
                    cls.fmt = FMT_R;
                end
                else if (f7 == F7_BASE && f3 == F3_SLTU)
                begin
                    cls.id  = ID_SLTU;
                    cls.fmt = FMT_R;
                end
                else if (f7 == F7_BASE && f3 == F3_SLT)
                begin
                    cls.id  = ID_SLT;
                    cls.fmt = FMT_R;
                end
            end
            OPC_TRAP:
            begin
                cls.id = ID_TRAP;
            end
            default:
            begin
                cls.id  = ID_INVALID;
                cls.fmt = FMT_NONE;
            end
        endcase
    end

endmodule

### rtl/rv32i_subset_instr_decoder.sv
// Decodes one 32-bit instruction word per transaction against a fixed RV32I
// subset (lw, sw, lui, auipc, addi, slti, sltiu, jal, jalr, beq, bne, add,
// sub, slt, sltu and the trap opcode) and returns the instruction id, the
// register indices, the sign-extended immediate and the register-write flag.
// The block takes one word every cycle unless the result channel stalls and
// passes each word through three register stages (classify, field extraction,
// write flag and output). A stall on the result channel fills the stages in
// front of it and then drops instr.ready; no transaction is lost or
// repeated. Words the subset does not cover come back with id 16 and all
// other fields zero.
module rv32i_subset_instr_decoder
    import rv32d_pkg::*;
(
    input  logic               clk,
    input  logic               rst_n,
    rv32d_instr_if.sink        instr,
    rv32d_result_if.source     result
);

    // Stage advance enables; a stage moves when it is empty or its
    // successor moves.
    logic en1, en2, en3;

    // Stage 1: classified word.
    logic                 v1_reg;
    logic [WordWidth-1:0] word1_reg;
    class_t               cls1_reg;
    class_t               cls1_next;

    // Stage 2: extracted fields.
    logic                   v2_reg;
    instr_id_t              id2_reg;
    fmt_t                   fmt2_reg;
    logic [RegIdxWidth-1:0] rd2_reg, rd2_next;
    logic [RegIdxWidth-1:0] rs1_2_reg, rs1_2_next;
    logic [RegIdxWidth-1:0] rs2_2_reg, rs2_2_next;
    logic [WordWidth-1:0]   imm2_reg, imm2_next;

    // Stage 3: output register.
    logic                   v3_reg;
    instr_id_t              id3_reg;
    logic [RegIdxWidth-1:0] rd3_reg, rs1_3_reg, rs2_3_reg;
    logic [WordWidth-1:0]   imm3_reg;
    logic                   wr3_reg, wr3_next;

    assign en3 = !v3_reg || result.ready;
    assign en2 = !v2_reg || en3;
    assign en1 = !v1_reg || en2;

    assign instr.ready = en1;

    // Opcode and function-code classification.
    rv32d_classify u_classify (
        .word (instr.instr_word),
        .cls  (cls1_next)
    );

    // Valid bits travel with the data.
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            v1_reg <= 1'b0;
            v2_reg <= 1'b0;
            v3_reg <= 1'b0;
        end
        else
        begin
            if (en1)
            begin
                v1_reg <= instr.valid;
            end
            if (en2)
            begin
                v2_reg <= v1_reg;
            end
            if (en3)
            begin
                v3_reg <= v2_reg;
            end
        end
    end

    // Stage 1 payload.
    always_ff @(posedge clk)
    begin
        if (en1)
        begin
            word1_reg <= instr.instr_word;
            cls1_reg  <= cls1_next;
        end
    end

    // Register indices and immediate by format; unused fields are zero.
    always_comb
    begin
        rd2_next   = '0;
        rs1_2_next = '0;
        rs2_2_next = '0;
        imm2_next  = '0;
        unique case (cls1_reg.fmt)
            FMT_I:
            begin
                rd2_next   = word1_reg[11:7];
                rs1_2_next = word1_reg[19:15];
                imm2_next  = {{20{word1_reg[31]}}, word1_reg[31:20]};
            end
            FMT_S:
            begin
                rs1_2_next = word1_reg[19:15];
                rs2_2_next = word1_reg[24:20];
                imm2_next  = {{20{word1_reg[31]}}, word1_reg[31:25], word1_reg[11:7]};
            end
            FMT_U:
            begin
                rd2_next  = word1_reg[11:7];
                imm2_next = {word1_reg[31:12], 12'b0};
            end
            FMT_J:
            begin
                rd2_next  = word1_reg[11:7];
                imm2_next = {{11{word1_reg[31]}}, word1_reg[31], word1_reg[19:12],
                             word1_reg[20], word1_reg[30:21], 1'b0};
            end
            FMT_B:
            begin
                rs1_2_next = word1_reg[19:15];
                rs2_2_next = word1_reg[24:20];
                imm2_next  = {{19{word1_reg[31]}}, word1_reg[31], word1_reg[7],
                              word1_reg[30:25], word1_reg[11:8], 1'b0};
            end
            FMT_R:
            begin
                rd2_next   = word1_reg[11:7];
                rs1_2_next = word1_reg[19:15];
                rs2_2_next = word1_reg[24:20];
            end
            default:
            begin
                rd2_next   = '0;
                rs1_2_next = '0;
                rs2_2_next = '0;
                imm2_next  = '0;
            end
        endcase
    end

    // Stage 2 payload.
    always_ff @(posedge clk)
    begin
        if (en2)
        begin
            id2_reg   <= cls1_reg.id;
            fmt2_reg  <= cls1_reg.fmt;
            rd2_reg   <= rd2_next;
            rs1_2_reg <= rs1_2_next;
            rs2_2_reg <= rs2_2_next;
            imm2_reg  <= imm2_next;
        end
    end

    // Formats with a destination write rd, unless rd is x0.
    always_comb
    begin
        wr3_next = (fmt2_reg inside {FMT_I, FMT_U, FMT_J, FMT_R}) && (rd2_reg != '0);
    end

    // Stage 3 payload, the output register.
    always_ff @(posedge clk)
    begin
        if (en3)
        begin
            id3_reg   <= id2_reg;
            rd3_reg   <= rd2_reg;
            rs1_3_reg <= rs1_2_reg;
            rs2_3_reg <= rs2_2_reg;
            imm3_reg  <= imm2_reg;
            wr3_reg   <= wr3_next;
        end
    end

    assign result.valid           = v3_reg;
    assign result.instr_id        = id3_reg;
    assign result.rd_index        = rd3_reg;
    assign result.rs1_index       = rs1_3_reg;
    assign result.rs2_index       = rs2_3_reg;
    assign result.immediate       = $signed(imm3_reg);
    assign result.writes_register = wr3_reg;

endmodule
